/* src/seven_segment_value_display_assert.svh */
// Assertion macros shared by the seven-segment display RTL.
// Each macro expects a signal named clk, and SVD_ASSERT_CLK also arst_n, in the using module.
`ifndef SEVEN_SEGMENT_VALUE_DISPLAY_ASSERT_SVH
`define SEVEN_SEGMENT_VALUE_DISPLAY_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define SVD_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds while reset is asserted.
`define SVD_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/svd_pkg.sv */
// Package for the seven-segment value display: mode codes, symbol codes,
// thresholds, reciprocal constants and the segment decoder. No dependencies.
`timescale 1ns / 1ps

package svd_pkg;

	typedef enum logic [1:0] {
		MODE_SHOW   = 2'd0,
		MODE_TICK   = 2'd1,
		MODE_TARGET = 2'd2
	} svd_mode_t;

	localparam logic [3:0] SYM_BAR   = 4'd10;
	localparam logic [3:0] SYM_BLANK = 4'd11;

	localparam logic [19:0] NEAR_MILLI   = 20'd5000;
	localparam logic [19:0] FAR_MILLI    = 20'd50000;
	localparam logic [19:0] RANGE_HI     = 20'd99900;
	localparam logic [19:0] RANGE_MID    = 20'd9990;
	localparam logic [19:0] TARGET_RESET = 20'd100000;

	// Scan position 4 is the degree mark; as a point position it lights nothing.
	localparam logic [2:0] SCAN_LAST   = 3'd4;
	localparam logic [2:0] POINT_RESET = 3'd1;
	localparam logic [2:0] POINT_HI    = 3'd4;
	localparam logic [2:0] POINT_MID   = 3'd2;
	localparam logic [2:0] POINT_LO    = 3'd3;

	localparam logic [6:0] SEG_C = 7'h04;

	// Exact division of a 20-bit value by a constant d: multiply by
	// ceil(2^s / d) with s = 20 + ceil(log2 d), then keep the bits above s.
	localparam int VALUE_W = 20;
	localparam int MUL_W   = 21;
	localparam int PROD_W  = VALUE_W + MUL_W;

	localparam int DIV10_SHIFT     = 24;
	localparam int DIV100_SHIFT    = 27;
	localparam int DIV1000_SHIFT   = 30;
	localparam int DIV10000_SHIFT  = 34;
	localparam int DIV100000_SHIFT = 37;

	localparam logic [MUL_W-1:0] DIV10_MUL =
		MUL_W'(((64'd1 << DIV10_SHIFT) + 64'd9) / 64'd10);
	localparam logic [MUL_W-1:0] DIV100_MUL =
		MUL_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
	localparam logic [MUL_W-1:0] DIV1000_MUL =
		MUL_W'(((64'd1 << DIV1000_SHIFT) + 64'd999) / 64'd1000);
	localparam logic [MUL_W-1:0] DIV10000_MUL =
		MUL_W'(((64'd1 << DIV10000_SHIFT) + 64'd9999) / 64'd10000);
	localparam logic [MUL_W-1:0] DIV100000_MUL =
		MUL_W'(((64'd1 << DIV100000_SHIFT) + 64'd99999) / 64'd100000);

	// Quotients of one value by the powers of ten.
	typedef struct packed {
		logic [16:0] q10;
		logic [13:0] q100;
		logic [10:0] q1000;
		logic [6:0]  q10000;
		logic [3:0]  q100000;
	} svd_quot_t;

	function automatic logic [6:0] seg_decode(input logic [3:0] sym);
		logic [6:0] seg;
		case (sym)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			SYM_BAR: seg = 7'h40;
			default: seg = 7'h00;
		endcase
		return seg;
	endfunction

endpackage

/* src/svd_channels.sv */
// Valid/ready channel interfaces of the seven-segment value display:
// the command channel and the display channel. No dependencies.
`timescale 1ns / 1ps

interface svd_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [19:0] value_milli;

	modport source(output valid, mode, value_milli, input ready);
	modport sink(input valid, mode, value_milli, output ready);
endinterface

interface svd_disp_if;
	logic       valid;
	logic       ready;
	logic [2:0] digit_select;
	logic [6:0] segments;
	logic       decimal_point;

	modport source(output valid, digit_select, segments, decimal_point, input ready);
	modport sink(input valid, digit_select, segments, decimal_point, output ready);
endinterface

/* src/seven_segment_value_display.sv */
// Top level of the seven-segment value display.
// Depends on svd_pkg, svd_channels (interfaces), svd_quot and the assert header.
//
// Usage:
// The cmd channel takes one item per command: show a value, advance the scan
// position, or set a target and enter direction mode. Every accepted item
// gives exactly one item on the disp channel: the scan position now lit, its
// segment drive and its decimal point, as they stand after the command.
// On the way from acceptance to disp.valid, the first register
// holds the command and its quotients by the powers of ten (one multiplier
// per divisor), the second holds the updated display state and the result.
// Throughput is one item per cycle while disp.ready is high.
// When the receiver stalls, the result is held and the command register
// still takes one more item; cmd.ready then falls until disp.ready returns.
// Reset clears both stages, shows digit 0 on all positions with the point
// on position 1, selects position 0, and sets the target to 100.000.
`timescale 1ns / 1ps

`include "seven_segment_value_display_assert.svh"

module seven_segment_value_display
	import svd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	svd_cmd_if.sink       cmd,
	svd_disp_if.source    disp
);

	function automatic logic [3:0] digit_of(input logic [3:0] hi, input logic [3:0] lo);
		logic [3:0] lo10;
		lo10 = lo * 4'd10;
		return hi - lo10;
	endfunction

	// Stage 1: command and quotients.
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [19:0] value_s1;
	svd_quot_t   quot_s1;
	svd_quot_t   quot_c;
	logic        advance;

	// Display state.
	logic [3:0]  digit_q [4];
	logic [2:0]  scan_q;
	logic [2:0]  point_q;
	logic        degree_q;
	logic        num_disp_q;
	logic        auto_q;
	logic [19:0] target_q;

	logic [3:0]  digit_nxt [4];
	logic [2:0]  scan_nxt;
	logic [2:0]  point_nxt;
	logic        degree_nxt;
	logic        num_disp_nxt;
	logic        auto_nxt;
	logic [19:0] target_nxt;

	// Output register.
	logic        out_valid_q;
	logic [2:0]  out_sel_q;
	logic [6:0]  out_seg_q;
	logic        out_dp_q;

	logic [3:0]  dig10, dig100, dig1000, dig10000, dig100000;
	logic [20:0] value_ext, target_ext;
	logic        near, below, far_below, far_above;
	logic [6:0]  seg_c;
	logic        dp_c;

	assign advance   = !out_valid_q || disp.ready;
	assign cmd.ready = !valid_s1 || advance;

	svd_quot u_quot (
		.value_milli(cmd.value_milli),
		.quot       (quot_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_s1  <= cmd.mode;
			value_s1 <= cmd.value_milli;
			quot_s1  <= quot_c;
		end
	end

	// Decimal digits of the stage 1 value.
	assign dig10     = digit_of(quot_s1.q10[3:0], quot_s1.q100[3:0]);
	assign dig100    = digit_of(quot_s1.q100[3:0], quot_s1.q1000[3:0]);
	assign dig1000   = digit_of(quot_s1.q1000[3:0], quot_s1.q10000[3:0]);
	assign dig10000  = digit_of(quot_s1.q10000[3:0], quot_s1.q100000);
	assign dig100000 = (quot_s1.q100000 >= 4'd10) ? quot_s1.q100000 - 4'd10
		: quot_s1.q100000;

	assign value_ext  = {1'b0, value_s1};
	assign target_ext = {1'b0, target_q};
	assign near       = (value_ext < target_ext + {1'b0, NEAR_MILLI})
		&& (value_ext + {1'b0, NEAR_MILLI} > target_ext);
	assign below      = value_s1 < target_q;
	assign far_below  = (target_q - value_s1) > FAR_MILLI;
	assign far_above  = (value_s1 - target_q) > FAR_MILLI;

	always_comb begin
		digit_nxt    = digit_q;
		scan_nxt     = scan_q;
		point_nxt    = point_q;
		degree_nxt   = degree_q;
		num_disp_nxt = num_disp_q;
		auto_nxt     = auto_q;
		target_nxt   = target_q;
		case (mode_s1)
			MODE_SHOW: begin
				if (!num_disp_q) begin
					degree_nxt = 1'b0;
					if (near) begin
						num_disp_nxt = 1'b1;
					end else if (below) begin
						digit_nxt[0] = SYM_BLANK;
						digit_nxt[1] = SYM_BLANK;
						digit_nxt[2] = SYM_BAR;
						digit_nxt[3] = far_below ? SYM_BAR : SYM_BLANK;
					end else begin
						digit_nxt[0] = far_above ? SYM_BAR : SYM_BLANK;
						digit_nxt[1] = SYM_BAR;
						digit_nxt[2] = SYM_BLANK;
						digit_nxt[3] = SYM_BLANK;
					end
				end else if (!auto_q) begin
					digit_nxt[0] = dig100;
					digit_nxt[1] = dig1000;
					digit_nxt[2] = dig10000;
					digit_nxt[3] = dig100000;
				end else begin
					degree_nxt   = 1'b1;
					digit_nxt[0] = SYM_BLANK;
					if (value_s1 > RANGE_HI) begin
						point_nxt    = POINT_HI;
						digit_nxt[1] = dig1000;
						digit_nxt[2] = dig10000;
						digit_nxt[3] = dig100000;
					end else if (value_s1 > RANGE_MID) begin
						point_nxt    = POINT_MID;
						digit_nxt[1] = dig100;
						digit_nxt[2] = dig1000;
						digit_nxt[3] = dig10000;
					end else begin
						point_nxt    = POINT_LO;
						digit_nxt[1] = dig10;
						digit_nxt[2] = dig100;
						digit_nxt[3] = dig1000;
					end
				end
			end
			MODE_TICK: begin
				scan_nxt = (scan_q == SCAN_LAST) ? 3'd0 : scan_q + 3'd1;
			end
			MODE_TARGET: begin
				target_nxt   = value_s1;
				num_disp_nxt = 1'b0;
				auto_nxt     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// The result shows the display after this item has taken effect.
	always_comb begin
		if (scan_nxt == SCAN_LAST) begin
			seg_c = degree_nxt ? SEG_C : 7'h00;
			dp_c  = 1'b0;
		end else begin
			seg_c = seg_decode(digit_nxt[scan_nxt[1:0]]);
			dp_c  = (scan_nxt == point_nxt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				digit_q[i] <= 4'd0;
			end
			scan_q      <= 3'd0;
			point_q     <= POINT_RESET;
			degree_q    <= 1'b0;
			num_disp_q  <= 1'b1;
			auto_q      <= 1'b0;
			target_q    <= TARGET_RESET;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				digit_q    <= digit_nxt;
				scan_q     <= scan_nxt;
				point_q    <= point_nxt;
				degree_q   <= degree_nxt;
				num_disp_q <= num_disp_nxt;
				auto_q     <= auto_nxt;
				target_q   <= target_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_sel_q <= scan_nxt;
			out_seg_q <= seg_c;
			out_dp_q  <= dp_c;
		end
	end

	assign disp.valid         = out_valid_q;
	assign disp.digit_select  = out_sel_q;
	assign disp.segments      = out_seg_q;
	assign disp.decimal_point = out_dp_q;

	`SVD_ASSERT_ANY(a_scan_range, scan_q <= SCAN_LAST, "scan position out of range")
	`SVD_ASSERT_ANY(a_degree_needs_auto, degree_q |-> auto_q, "degree mark outside auto range")
	`SVD_ASSERT_CLK(a_tick_wraps, (valid_s1 && advance && mode_s1 == MODE_TICK) |=> (scan_q == (($past(scan_q) == SCAN_LAST) ? 3'd0 : $past(scan_q) + 3'd1)), "scan tick did not advance modulo five")
	`SVD_ASSERT_CLK(a_target_enters_dir, (valid_s1 && advance && mode_s1 == MODE_TARGET) |=> (!num_disp_q && auto_q && out_valid_q), "set target did not enter direction mode")
	`SVD_ASSERT_CLK(a_degree_no_point, (disp.valid && disp.digit_select == SCAN_LAST) |-> !disp.decimal_point, "point lit on the degree position")

endmodule

/* src/svd_quot.sv */
// Divides a 20-bit value by 10, 100, 1000, 10000 and 100000 in parallel
// with reciprocal multipliers. Depends on svd_pkg.
`timescale 1ns / 1ps

module svd_quot
	import svd_pkg::*;
(
	input  logic [19:0] value_milli,
	output svd_quot_t   quot
);

	logic [PROD_W-1:0] p10;
	logic [PROD_W-1:0] p100;
	logic [PROD_W-1:0] p1000;
	logic [PROD_W-1:0] p10000;
	logic [PROD_W-1:0] p100000;

	assign p10     = PROD_W'(value_milli) * PROD_W'(DIV10_MUL);
	assign p100    = PROD_W'(value_milli) * PROD_W'(DIV100_MUL);
	assign p1000   = PROD_W'(value_milli) * PROD_W'(DIV1000_MUL);
	assign p10000  = PROD_W'(value_milli) * PROD_W'(DIV10000_MUL);
	assign p100000 = PROD_W'(value_milli) * PROD_W'(DIV100000_MUL);

	assign quot.q10     = p10[PROD_W-1:DIV10_SHIFT];
	assign quot.q100    = p100[PROD_W-1:DIV100_SHIFT];
	assign quot.q1000   = p1000[PROD_W-1:DIV1000_SHIFT];
	assign quot.q10000  = p10000[PROD_W-1:DIV10000_SHIFT];
	assign quot.q100000 = p100000[PROD_W-1:DIV100000_SHIFT];

endmodule
